### rtl/fdt_pkg.sv
package fdt_pkg;

    // seconds in the calendar units used by the conversion
    localparam int unsigned FOUR_YEAR_SECS = 126230400;
    localparam int unsigned DAY_SECS       = 86400;
    localparam int unsigned HOUR_SECS      = 3600;
    localparam int unsigned MIN_SECS       = 60;

    // offset inside a four-year cycle, offset inside one year
    typedef logic [26:0] cycle_secs_t;
    typedef logic [24:0] year_secs_t;

    // start of each year inside a four-year cycle, first year is leap
    localparam cycle_secs_t YEAR_START [4] = '{
        27'd0, 27'd31622400, 27'd63158400, 27'd94694400
    };

    // start of each month inside a common year
    localparam year_secs_t MONTH_START_COMMON [12] = '{
        25'd0,        25'd2678400,  25'd5097600,  25'd7776000,
        25'd10368000, 25'd13046400, 25'd15638400, 25'd18316800,
        25'd20995200, 25'd23587200, 25'd26265600, 25'd28857600
    };

    // start of each month inside a leap year
    localparam year_secs_t MONTH_START_LEAP [12] = '{
        25'd0,        25'd2678400,  25'd5184000,  25'd7862400,
        25'd10454400, 25'd13132800, 25'd15724800, 25'd18403200,
        25'd21081600, 25'd23673600, 25'd26352000, 25'd28944000
    };

    // load enables of the three stages of a constant divider
    typedef struct packed {
        logic mul;
        logic sub;
        logic fix;
    } div_en_t;

    // calendar fields that ride along with the time-of-day divisions
    typedef struct packed {
        logic [7:0] years;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
    } side_t;

endpackage

### rtl/epoch_seconds_to_fat_datetime_top.sv
// Converts a count of seconds since 1980-01-01 00:00:00 into the packed FAT
// date-time word (year-1980, month, day, hour, minute, seconds/2), with
// year_overflow set when the year passes 2107 and its field wraps. Every
// fourth year starting with 1980 counts as leap, 2100 included. The block is
// a 15-stage pipeline that takes one beat every cycle unless seconds_stall is
// high. The depth is set by four chained divisions by constants (four-year
// cycle, day, hour, minute), each three stages of reciprocal multiply,
// subtract and correct, plus the year search, the month search and the output
// register. Empty stages close up, so beats are still taken while a finished
// result waits on result_stall.
module epoch_seconds_to_fat_datetime_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seconds_valid,
    output logic        seconds_stall,
    input  logic [31:0] seconds_count,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] fat_datetime,
    output logic        year_overflow
);
    import fdt_pkg::*;

    localparam int NS         = 15;
    localparam int ST_YEAR    = 3;
    localparam int ST_MONTH   = 4;
    localparam int ST_DAY     = 5;
    localparam int ST_HOUR    = 8;
    localparam int ST_MIN     = 11;
    localparam int ST_OUT     = 14;
    localparam int SIDE_FIRST = 5;
    localparam int SIDE_LAST  = 13;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    div_en_t cyc_en;
    div_en_t day_en;
    div_en_t hour_en;
    div_en_t min_en;

    logic [5:0]  cyc_q;
    cycle_secs_t cyc_r;
    logic [4:0]  day_q;
    logic [16:0] day_r;
    logic [4:0]  hour_q;
    logic [11:0] hour_r;
    logic [5:0]  min_q;
    logic [5:0]  min_r;

    logic [1:0]  yoff;
    year_secs_t  yr_rem_next;
    logic [7:0]  yr_years_reg;
    logic        yr_leap_reg;
    year_secs_t  yr_rem_reg;

    logic [3:0]  mi;
    year_secs_t  mo_start;
    logic [21:0] mo_rem_next;
    logic [7:0]  mo_years_reg;
    logic [3:0]  mo_month_reg;
    logic [21:0] mo_rem_reg;

    side_t side_next [SIDE_FIRST:SIDE_LAST];
    side_t side_reg  [SIDE_FIRST:SIDE_LAST];

    logic [31:0] fat_next;
    logic [31:0] fat_reg;
    logic        ovf_reg;

    // stage loads when empty or when the next stage moves on
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !result_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign seconds_stall = !en[0];

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= seconds_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign cyc_en  = '{mul: en[0], sub: en[1], fix: en[2]};
    assign day_en  = '{mul: en[ST_DAY], sub: en[ST_DAY+1], fix: en[ST_DAY+2]};
    assign hour_en = '{mul: en[ST_HOUR], sub: en[ST_HOUR+1], fix: en[ST_HOUR+2]};
    assign min_en  = '{mul: en[ST_MIN], sub: en[ST_MIN+1], fix: en[ST_MIN+2]};

    // split into whole four-year cycles
    fdt_cdiv #(
        .IN_W    (32),
        .DIVISOR (FOUR_YEAR_SECS),
        .Q_W     (6),
        .R_W     (27)
    ) u_cyc_div (
        .clk       (clk),
        .en        (cyc_en),
        .dividend  (seconds_count),
        .quotient  (cyc_q),
        .remainder (cyc_r)
    );

    // year inside the cycle
    always_comb
    begin
        yoff = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (cyc_r >= YEAR_START[i])
            begin
                yoff = 2'(i);
            end
        end
        yr_rem_next = year_secs_t'(cyc_r - YEAR_START[yoff]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_YEAR])
        begin
            yr_years_reg <= {cyc_q, yoff};
            yr_leap_reg  <= (yoff == 2'd0);
            yr_rem_reg   <= yr_rem_next;
        end
    end

    // month by threshold search in the leap or common table
    always_comb
    begin
        mi = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (yr_rem_reg >= (yr_leap_reg ? MONTH_START_LEAP[i] : MONTH_START_COMMON[i]))
            begin
                mi = 4'(i);
            end
        end
        mo_start    = yr_leap_reg ? MONTH_START_LEAP[mi] : MONTH_START_COMMON[mi];
        mo_rem_next = 22'(yr_rem_reg - mo_start);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MONTH])
        begin
            mo_years_reg <= yr_years_reg;
            mo_month_reg <= 4'(mi + 4'd1);
            mo_rem_reg   <= mo_rem_next;
        end
    end

    // day, hour and minute by constant division
    fdt_cdiv #(
        .IN_W    (22),
        .DIVISOR (DAY_SECS),
        .Q_W     (5),
        .R_W     (17)
    ) u_day_div (
        .clk       (clk),
        .en        (day_en),
        .dividend  (mo_rem_reg),
        .quotient  (day_q),
        .remainder (day_r)
    );

    fdt_cdiv #(
        .IN_W    (17),
        .DIVISOR (HOUR_SECS),
        .Q_W     (5),
        .R_W     (12)
    ) u_hour_div (
        .clk       (clk),
        .en        (hour_en),
        .dividend  (day_r),
        .quotient  (hour_q),
        .remainder (hour_r)
    );

    fdt_cdiv #(
        .IN_W    (12),
        .DIVISOR (MIN_SECS),
        .Q_W     (6),
        .R_W     (6)
    ) u_min_div (
        .clk       (clk),
        .en        (min_en),
        .dividend  (hour_r),
        .quotient  (min_q),
        .remainder (min_r)
    );

    // calendar fields delayed alongside the dividers
    always_comb
    begin
        side_next[SIDE_FIRST] = '{
            years: mo_years_reg,
            month: mo_month_reg,
            day:   5'd0,
            hour:  5'd0
        };
        for (int i = SIDE_FIRST + 1; i <= SIDE_LAST; i++)
        begin
            side_next[i] = side_reg[i-1];
            if (i == ST_HOUR)
            begin
                side_next[i].day = 5'(day_q + 5'd1);
            end
            if (i == ST_MIN)
            begin
                side_next[i].hour = hour_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = SIDE_FIRST; i <= SIDE_LAST; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // pack the FAT word
    assign fat_next = {
        side_reg[SIDE_LAST].years[6:0],
        side_reg[SIDE_LAST].month,
        side_reg[SIDE_LAST].day,
        side_reg[SIDE_LAST].hour,
        min_q,
        min_r[5:1]
    };

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            fat_reg <= fat_next;
            ovf_reg <= side_reg[SIDE_LAST].years[7];
        end
    end

    assign result_valid  = v_reg[NS-1];
    assign fat_datetime  = fat_reg;
    assign year_overflow = ovf_reg;

    // input only stalls when every stage is full and the output is held
    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        seconds_stall |-> (result_valid && result_stall))
        else $error("input stalled while the pipeline has room");

    // month field is a real month
    a_month_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fat_datetime[24:21] >= 4'd1 && fat_datetime[24:21] <= 4'd12))
        else $error("month field out of range");

    // day and time-of-day fields stay in range
    a_time_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fat_datetime[20:16] != 5'd0 && fat_datetime[15:11] < 5'd24 &&
                          fat_datetime[10:5] < 6'd60 && fat_datetime[4:0] < 5'd30))
        else $error("day or time field out of range");

endmodule

### rtl/fdt_cdiv.sv
module fdt_cdiv #(
    parameter int          IN_W    = 32,
    parameter int unsigned DIVISOR = 126230400,
    parameter int          Q_W     = 6,
    parameter int          R_W     = 27
) (
    input  logic                clk,
    input  fdt_pkg::div_en_t    en,
    input  logic [IN_W-1:0]     dividend,
    output logic [Q_W-1:0]      quotient,
    output logic [R_W-1:0]      remainder
);
    import fdt_pkg::*;

    // reciprocal scaled by 2^IN_W, the estimate is low by at most one
    localparam int              PW      = 2 * IN_W;
    localparam longint unsigned RECIP_L = (64'd1 << IN_W) / DIVISOR;
    localparam logic [IN_W-1:0] RECIP   = IN_W'(RECIP_L);
    localparam logic [R_W:0]    DIV_R   = (R_W + 1)'(DIVISOR);

    logic [PW-1:0]   prod;
    logic [Q_W-1:0]  qe_next;
    logic [Q_W-1:0]  qe_reg;
    logic [IN_W-1:0] x_reg;
    logic [IN_W-1:0] qd;
    logic [R_W:0]    r_next;
    logic [R_W:0]    r_reg;
    logic [Q_W-1:0]  q2_reg;
    logic            fix;
    logic [Q_W-1:0]  quotient_next;
    logic [R_W-1:0]  remainder_next;
    logic [Q_W-1:0]  quotient_reg;
    logic [R_W-1:0]  remainder_reg;

    // stage 1: quotient estimate by reciprocal multiply
    assign prod    = PW'(dividend) * PW'(RECIP);
    assign qe_next = Q_W'(prod >> IN_W);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            x_reg  <= dividend;
            qe_reg <= qe_next;
        end
    end

    // stage 2: partial remainder, below twice the divisor
    assign qd     = IN_W'(qe_reg * DIVISOR);
    assign r_next = (R_W + 1)'(x_reg - qd);

    always_ff @(posedge clk)
    begin
        if (en.sub)
        begin
            r_reg  <= r_next;
            q2_reg <= qe_reg;
        end
    end

    // stage 3: one compare and subtract fixes the estimate
    assign fix            = (r_reg >= DIV_R);
    assign quotient_next  = fix ? Q_W'(q2_reg + 1'b1) : q2_reg;
    assign remainder_next = fix ? R_W'(r_reg - DIV_R) : R_W'(r_reg);

    always_ff @(posedge clk)
    begin
        if (en.fix)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
        end
    end

    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CYCLE_SECS    = 126230400;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned COMMON_YEAR   = 31536000;
    localparam int unsigned RANDOM_BEATS  = 2000;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned LONG_HOLD     = 300;

    // expected output of one beat
    typedef struct packed {
        logic [31:0] stamp;
        logic        ovf;
    } fat_stamp_t;

    // predicts fat stamps for accepted inputs and checks them in order
    class fat_stamp_scoreboard;
        fat_stamp_t pending_stamps[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // days from Jan 1 to the first day of month m (0-based)
        static function int unsigned month_first_day(int unsigned m, bit leap);
            int unsigned d;
            case (m)
                0: d = 0;
                1: d = 31;
                2: d = 59;
                3: d = 90;
                4: d = 120;
                5: d = 151;
                6: d = 181;
                7: d = 212;
                8: d = 243;
                9: d = 273;
                10: d = 304;
                default: d = 334;
            endcase
            if (leap && m >= 2)
                d = d + 1;
            return d;
        endfunction

        // seconds from the start of a four-year cycle to year yoff
        static function int unsigned year_first_sec(int unsigned yoff);
            return yoff * COMMON_YEAR + ((yoff > 0) ? SECS_PER_DAY : 0);
        endfunction

        function fat_stamp_t fat_stamp_of(logic [31:0] secs);
            fat_stamp_t r;
            int unsigned cyc, rem, yoff, years, month, day, hour, minute, half;
            cyc  = secs / CYCLE_SECS;
            rem  = secs % CYCLE_SECS;
            // year inside the cycle, first one leap
            yoff = 0;
            for (int unsigned i = 1; i < 4; i++)
                if (rem >= year_first_sec(i))
                    yoff = i;
            rem   = rem - year_first_sec(yoff);
            years = cyc * 4 + yoff;
            // month, the boundary second goes to the new month
            month = 1;
            for (int unsigned m = 1; m < 12; m++)
                if (rem >= month_first_day(m, yoff == 0) * SECS_PER_DAY)
                    month = m + 1;
            rem    = rem - month_first_day(month - 1, yoff == 0) * SECS_PER_DAY;
            day    = rem / SECS_PER_DAY + 1;
            rem    = rem % SECS_PER_DAY;
            hour   = rem / 3600;
            rem    = rem % 3600;
            minute = rem / 60;
            half   = (rem % 60) / 2;
            r.stamp = {years[6:0], month[3:0], day[4:0], hour[4:0], minute[5:0], half[4:0]};
            r.ovf   = (years > 127);
            return r;
        endfunction

        function void note_input(logic [31:0] secs);
            pending_stamps.push_back(fat_stamp_of(secs));
        endfunction

        function void check_result(logic [31:0] stamp, logic ovf);
            fat_stamp_t exp_r;
            if (pending_stamps.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h ovf %b",
                         $time, stamp, ovf);
                errors++;
                return;
            end
            exp_r = pending_stamps.pop_front();
            if (stamp !== exp_r.stamp)
            begin
                $display("%0t: fat_datetime mismatch, expected %h, actual %h",
                         $time, exp_r.stamp, stamp);
                errors++;
            end
            if (ovf !== exp_r.ovf)
            begin
                $display("%0t: year_overflow mismatch, expected %b, actual %b",
                         $time, exp_r.ovf, ovf);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_stamps.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seconds_valid = 1'b0;
    logic        seconds_stall;
    logic [31:0] seconds_count = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] fat_datetime;
    logic        year_overflow;

    fat_stamp_scoreboard sb;
    bit          no_gaps = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned idle_cycles = 0;

    epoch_seconds_to_fat_datetime_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .seconds_valid (seconds_valid),
        .seconds_stall (seconds_stall),
        .seconds_count (seconds_count),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .fat_datetime  (fat_datetime),
        .year_overflow (year_overflow)
    );

    always #2 clk = ~clk;

    // offer one input beat and wait until it is taken
    task automatic send_seconds(logic [31:0] secs);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            seconds_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seconds_valid <= 1'b1;
        seconds_count <= secs;
        do @(posedge clk); while (seconds_stall);
    endtask

    // random seconds count, biased toward year and month boundaries
    function automatic logic [31:0] pick_seconds();
        logic [63:0] base;
        int unsigned mode, yoff, m;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return $urandom;
        yoff = $urandom_range(0, 3);
        m    = $urandom_range(0, 11);
        if (mode < 8)
            base = 64'($urandom_range(0, 34)) * CYCLE_SECS;
        else
            base = 64'($urandom_range(30, 33)) * CYCLE_SECS;
        base = base + fat_stamp_scoreboard::year_first_sec(yoff)
             + 64'(fat_stamp_scoreboard::month_first_day(m, yoff == 0)) * SECS_PER_DAY;
        if ($urandom_range(0, 1) == 0)
            base = base + $urandom_range(0, 6) - 3;
        else
            base = base + $urandom_range(0, 31 * SECS_PER_DAY);
        return base[31:0];
    endfunction

    // beat monitor and idle watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seconds_valid && !seconds_stall)
                sb.note_input(seconds_count);
            if (result_valid && !result_stall)
                sb.check_result(fat_datetime, year_overflow);
            if ((seconds_valid && !seconds_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
                $display("FAIL epoch_seconds_to_fat_datetime_top");
                $finish;
            end
        end
    end

    // result side: random stall per beat, one long hold-off on request
    initial
    begin
        int unsigned n;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                n = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                n = no_gaps ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [31:0] directed[$];
        sb = new();
        directed = '{
            32'd0, 32'd1, 32'd59, 32'd61, 32'd86399, 32'd86400,
            32'd5097600,                      // feb 29 of a leap year
            32'd5183999, 32'd5184000,         // last second of feb, mar 1
            32'd31622399, 32'd31622400,       // first year boundary
            32'd31622400 + 32'd2678400,       // feb 1 of a common year
            32'd63158399, 32'd63158400, 32'd94694400,
            32'd126230399, 32'd126230400,     // cycle boundary
            32'd3786912000 + 32'd5097600,     // feb 29 2100, no century rule
            32'd4039372799, 32'd4039372800,   // year field wrap
            32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_seconds(directed[i]);

        for (int unsigned k = 0; k < RANDOM_BEATS; k++)
        begin
            // alternate stretches with and without idling
            if (k % 150 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            // fill the pipeline against a long output hold-off
            if (k == RANDOM_BEATS / 2)
            begin
                no_gaps = 1'b1;
                hold_request = 1'b1;
            end
            send_seconds(pick_seconds());
        end
        seconds_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS epoch_seconds_to_fat_datetime_top");
        else
            $display("FAIL epoch_seconds_to_fat_datetime_top");
        $finish;
    end

endmodule

### sim.f
rtl/fdt_pkg.sv
rtl/fdt_cdiv.sv
rtl/epoch_seconds_to_fat_datetime_top.sv
dv/tb_top.sv
